// ----- hdl/vasd_pkg.sv -----
// Package for vector_angle_sum_difference: request selector codes and result format constants.
// No dependencies.
package vasd_pkg;

   typedef enum logic [1:0] {
      OP_COS_SUM  = 2'd0,
      OP_COS_DIFF = 2'd1,
      OP_SIN_SUM  = 2'd2,
      OP_SIN_DIFF = 2'd3
   } op_type;

   localparam int RES_WIDTH = 16;
   localparam int K_BITS    = 16;
   localparam int FRAC_SH   = 32;
   localparam logic [RES_WIDTH-1:0] RES_MAX = 16'h7fff;

endpackage

// ----- hdl/vector_angle_sum_difference.sv -----
// Top level of vector_angle_sum_difference: cosine or sine of the sum or difference of two
// vector angles in Q1.15. Depends on vasd_pkg.
//
// Accepts one request per clock unless the response side stalls, and returns one response
// per request, in order. Three stages form the products, the squared lengths, the numerator
// N, its square and Q = P1*P2; a fourth forms the starting remainder N^2*2^32 - Q; then one
// stage a bit resolves the 16-bit rounded magnitude K with a shift, add and compare of about
// 4*IN_WIDTH+36 bits, and a last stage saturates and signs the value. A stall on the
// response side holds the whole pipeline; nothing is dropped.
module vector_angle_sum_difference #(
   parameter int IN_WIDTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // first_x, first_y, second_x, second_y from bit 0 up, zero padded
   input  logic [((4*IN_WIDTH+7)/8)*8-1:0]       req_tdata,
   // op
   input  logic [1:0]                            req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // trig_value
   output logic [vasd_pkg::RES_WIDTH-1:0]        rsp_tdata,
   // zero_length
   output logic                                  rsp_tuser
);

   localparam int W   = IN_WIDTH;
   localparam int PW  = 2*W;
   localparam int QW  = 4*W;
   localparam int LW  = 4*W + 36;
   localparam int NIT = vasd_pkg::K_BITS;

   logic en;
   assign en = rsp_tready || !rsp_tvalid;
   assign req_tready = en;

   logic signed [W-1:0] fx, fy, sx, sy;
   vasd_pkg::op_type op;
   assign fx = req_tdata[W-1:0];
   assign fy = req_tdata[2*W-1:W];
   assign sx = req_tdata[3*W-1:2*W];
   assign sy = req_tdata[4*W-1:3*W];
   assign op = vasd_pkg::op_type'(req_tuser);

   // stage 1: products
   logic                 s1_v_ff, s1_negb_ff;
   logic signed [PW-1:0] s1_xx1_ff, s1_yy1_ff, s1_xx2_ff, s1_yy2_ff, s1_a_ff, s1_b_ff;
   logic signed [PW-1:0] s1_a_in, s1_b_in;
   logic                 s1_negb_in;

   always_comb begin
      if (op == vasd_pkg::OP_COS_SUM || op == vasd_pkg::OP_COS_DIFF) begin
         s1_a_in = fx * sx;
         s1_b_in = fy * sy;
      end else begin
         s1_a_in = fy * sx;
         s1_b_in = fx * sy;
      end
      s1_negb_in = (op == vasd_pkg::OP_COS_SUM) || (op == vasd_pkg::OP_SIN_DIFF);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff <= req_tvalid;
      end
      if (en) begin
         s1_xx1_ff  <= fx * fx;
         s1_yy1_ff  <= fy * fy;
         s1_xx2_ff  <= sx * sx;
         s1_yy2_ff  <= sy * sy;
         s1_a_ff    <= s1_a_in;
         s1_b_ff    <= s1_b_in;
         s1_negb_ff <= s1_negb_in;
      end
   end

   // stage 2: squared lengths and numerator
   logic               s2_v_ff, s2_zero_ff;
   logic [PW-1:0]      s2_p1_ff, s2_p2_ff, s2_p1_in, s2_p2_in;
   logic signed [PW:0] s2_n_ff, s2_n_in;

   always_comb begin
      s2_p1_in = $unsigned(s1_xx1_ff) + $unsigned(s1_yy1_ff);
      s2_p2_in = $unsigned(s1_xx2_ff) + $unsigned(s1_yy2_ff);
      if (s1_negb_ff) begin
         s2_n_in = {s1_a_ff[PW-1], s1_a_ff} - {s1_b_ff[PW-1], s1_b_ff};
      end else begin
         s2_n_in = {s1_a_ff[PW-1], s1_a_ff} + {s1_b_ff[PW-1], s1_b_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (en) begin
         s2_v_ff <= s1_v_ff;
      end
      if (en) begin
         s2_p1_ff   <= s2_p1_in;
         s2_p2_ff   <= s2_p2_in;
         s2_n_ff    <= s2_n_in;
         s2_zero_ff <= (s2_p1_in == '0) || (s2_p2_in == '0);
      end
   end

   // stage 3: Q = P1*P2 and N^2
   logic                    s3_v_ff, s3_zero_ff, s3_neg_ff;
   logic [QW-1:0]           s3_q_ff, s3_nsq_ff;
   logic signed [2*PW+1:0]  nn_full;

   assign nn_full = s2_n_ff * s2_n_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (en) begin
         s3_v_ff <= s2_v_ff;
      end
      if (en) begin
         s3_q_ff    <= s2_p1_ff * s2_p2_ff;
         s3_nsq_ff  <= nn_full[QW-1:0];
         s3_neg_ff  <= s2_n_ff[PW];
         s3_zero_ff <= s2_zero_ff;
      end
   end

   // stage 4 and bit stages: rem = N^2*2^32 - (2K-1)^2*Q, t = (2K-1)*Q
   logic                 it_v_ff    [0:NIT];
   logic                 it_neg_ff  [0:NIT];
   logic                 it_zero_ff [0:NIT];
   logic                 it_small_ff[0:NIT];
   logic signed [LW-1:0] it_rem_ff  [0:NIT];
   logic signed [LW-1:0] it_t_ff    [0:NIT];
   logic        [QW-1:0] it_q_ff    [0:NIT];
   logic [NIT-1:0]       it_k_ff    [0:NIT];

   logic signed [LW-1:0] r_ext, q_ext, rem0_in;
   assign r_ext   = {{(LW-QW-vasd_pkg::FRAC_SH){1'b0}}, s3_nsq_ff,
                     {vasd_pkg::FRAC_SH{1'b0}}};
   assign q_ext   = {{(LW-QW){1'b0}}, s3_q_ff};
   assign rem0_in = r_ext - q_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         it_v_ff[0] <= 1'b0;
      end else if (en) begin
         it_v_ff[0] <= s3_v_ff;
      end
      if (en) begin
         it_neg_ff[0]   <= s3_neg_ff;
         it_zero_ff[0]  <= s3_zero_ff;
         it_small_ff[0] <= rem0_in[LW-1];
         it_rem_ff[0]   <= rem0_in;
         it_t_ff[0]     <= -q_ext;
         it_q_ff[0]     <= s3_q_ff;
         it_k_ff[0]     <= '0;
      end
   end

   for (genvar i = 0; i < NIT; i++) begin : g_bit
      localparam int J = NIT - 1 - i;
      logic signed [LW-1:0] qx, cand;
      logic                 take;
      assign qx   = {{(LW-QW){1'b0}}, it_q_ff[i]};
      assign cand = (it_t_ff[i] <<< (J+2)) + (qx <<< (2*J+2));
      assign take = !it_small_ff[i] && (cand <= it_rem_ff[i]);

      always_ff @(posedge clock) begin
         if (reset) begin
            it_v_ff[i+1] <= 1'b0;
         end else if (en) begin
            it_v_ff[i+1] <= it_v_ff[i];
         end
         if (en) begin
            it_neg_ff[i+1]   <= it_neg_ff[i];
            it_zero_ff[i+1]  <= it_zero_ff[i];
            it_small_ff[i+1] <= it_small_ff[i];
            it_q_ff[i+1]     <= it_q_ff[i];
            if (take) begin
               it_rem_ff[i+1] <= it_rem_ff[i] - cand;
               it_t_ff[i+1]   <= it_t_ff[i] + (qx <<< (J+1));
               it_k_ff[i+1]   <= it_k_ff[i] | (NIT'(1) << J);
            end else begin
               it_rem_ff[i+1] <= it_rem_ff[i];
               it_t_ff[i+1]   <= it_t_ff[i];
               it_k_ff[i+1]   <= it_k_ff[i];
            end
         end
      end
   end

   // output stage
   logic                              rsp_valid_ff, rsp_zero_ff;
   logic [vasd_pkg::RES_WIDTH-1:0]    rsp_value_ff, rsp_value_in;
   logic [NIT-1:0]                    kf;

   assign kf = it_k_ff[NIT];

   always_comb begin
      if (it_zero_ff[NIT]) begin
         rsp_value_in = '0;
      end else if (it_neg_ff[NIT]) begin
         rsp_value_in = vasd_pkg::RES_WIDTH'(-kf);
      end else if (kf > NIT'(vasd_pkg::RES_MAX)) begin
         rsp_value_in = vasd_pkg::RES_MAX;
      end else begin
         rsp_value_in = vasd_pkg::RES_WIDTH'(kf);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= it_v_ff[NIT];
      end
      if (en) begin
         rsp_value_ff <= rsp_value_in;
         rsp_zero_ff  <= it_zero_ff[NIT];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_zero_ff;

`ifndef SYNTHESIS
   a_zero_value: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("zero-length response carries a nonzero value");

   a_hold_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("pipeline not accepting with empty output");

   a_rem_nonneg: assert property (@(posedge clock) disable iff (reset)
      it_v_ff[NIT] && !it_small_ff[NIT] |-> !it_rem_ff[NIT][LW-1])
      else $error("remainder went negative");
`endif

endmodule

// ----- bench/tb_vector_angle_sum_difference.sv -----
// Testbench for vector_angle_sum_difference: drives vector pairs and selectors on the request
// stream and checks each response against an exact-integer predictor of the rounded Q1.15 value.
// Depends on vasd_pkg and the vector_angle_sum_difference RTL.
`timescale 1ns / 1ps

module tb_vector_angle_sum_difference;

   localparam int IN_WIDTH = 16;
   localparam int DW = ((4*IN_WIDTH+7)/8)*8;

   typedef struct packed {
      logic [15:0] trig_value;
      logic        zero_length;
   } trig_result_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [DW-1:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [vasd_pkg::RES_WIDTH-1:0] rsp_tdata;
   logic rsp_tuser;

   trig_result_type expected_q[$];
   int errors = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_active = 0;
   event hold_start;

   vector_angle_sum_difference #(.IN_WIDTH(IN_WIDTH)) i_dut (.*);

   always #4 clock = ~clock;

   initial begin
      #50ms;
      $display("Verification failed");
      $finish;
   end

   // Round-to-nearest of 32768*|N|/sqrt(P1*P2), found by bisection on exact products.
   function automatic trig_result_type predict_trig(vasd_pkg::op_type op,
         logic signed [15:0] x1, logic signed [15:0] y1, logic signed [15:0] x2,
         logic signed [15:0] y2);
      logic signed [63:0] p1, p2, n;
      logic [255:0] q, rhs, lhs, mag;
      logic [31:0] lo, hi, mid;
      logic [63:0] odd;
      trig_result_type r;
      p1 = x1*x1 + y1*y1;
      p2 = x2*x2 + y2*y2;
      r = '0;
      if (p1 == 0 || p2 == 0) begin
         r.zero_length = 1'b1;
         return r;
      end
      case (op)
         vasd_pkg::OP_COS_SUM:  n = x1*x2 - y1*y2;
         vasd_pkg::OP_COS_DIFF: n = x1*x2 + y1*y2;
         vasd_pkg::OP_SIN_SUM:  n = y1*x2 + x1*y2;
         default:               n = y1*x2 - x1*y2;
      endcase
      mag = (n < 0) ? -n : n;
      q = 256'(p1) * 256'(p2);
      rhs = (mag * mag) << 32;
      lo = 0;
      hi = 32768;
      while (lo < hi) begin
         mid = lo + (hi - lo + 1) / 2;
         odd = 2*mid - 1;
         lhs = 256'(odd) * 256'(odd) * q;
         if (lhs <= rhs) lo = mid;
         else hi = mid - 1;
      end
      if (n < 0) r.trig_value = -lo[15:0];
      else r.trig_value = (lo > 32767) ? vasd_pkg::RES_MAX : lo[15:0];
      return r;
   endfunction

   task automatic send_request(vasd_pkg::op_type op, logic [15:0] x1, logic [15:0] y1,
         logic [15:0] x2, logic [15:0] y2);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= op;
      req_tdata <= {y2, x2, y1, x1};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_q.push_back(predict_trig(op, x1, y1, x2, y2));
      @(negedge clock);
   endtask

   function automatic logic [15:0] rand_comp();
      case ($urandom_range(5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'($signed($urandom_range(8)) - 4);
         default: return 16'($urandom);
      endcase
   endfunction

   // Long hold-off window, counted here in cycles.
   always begin
      @(hold_start);
      hold_active = 1;
      repeat (200) @(negedge clock);
      hold_active = 0;
   end

   // Receiver: random stalls, or held off during a hold window.
   always @(negedge clock) begin
      if (hold_active) begin
         rsp_tready <= 0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      trig_result_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_q.size() == 0) begin
            $error("unexpected response %h/%b", rsp_tdata, rsp_tuser);
            errors++;
         end else begin
            e = expected_q.pop_front();
            if (rsp_tdata !== e.trig_value) begin
               $error("trig_value expected %0d got %0d", $signed(e.trig_value),
                      $signed(rsp_tdata));
               errors++;
            end
            if (rsp_tuser !== e.zero_length) begin
               $error("zero_length expected %b got %b", e.zero_length, rsp_tuser);
               errors++;
            end
         end
      end
   end

   task automatic test_directed();
      vasd_pkg::op_type op;
      for (int i = 0; i < 4; i++) begin
         op = vasd_pkg::op_type'(i);
         send_request(op, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
         send_request(op, 16'h7fff, 16'h0000, 16'h7fff, 16'h0000);
         send_request(op, 16'h0000, 16'h0000, 16'h0003, 16'h0004);
         send_request(op, 16'h0001, 16'h0001, 16'h0000, 16'h0000);
         send_request(op, 16'h7fff, 16'h8000, 16'hffff, 16'h0001);
      end
      send_request(vasd_pkg::OP_COS_DIFF, 16'h0003, 16'h0004, 16'h0003, 16'h0004);
      send_request(vasd_pkg::OP_SIN_SUM, 16'h0000, 16'h0001, 16'h0001, 16'h0000);
      send_request(vasd_pkg::OP_SIN_DIFF, 16'h0000, 16'hffff, 16'h0001, 16'h0000);
   endtask

   task automatic test_random(int count);
      for (int i = 0; i < count; i++)
         send_request(vasd_pkg::op_type'($urandom_range(3)), rand_comp(), rand_comp(),
                      rand_comp(), rand_comp());
   endtask

   task automatic test_backpressure();
      -> hold_start;
      test_random(60);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      send_idle_pct = 22;
      recv_idle_pct = 46;
      test_directed();
      test_random(350);
      send_idle_pct = 46;
      recv_idle_pct = 22;
      test_random(350);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_backpressure();
      test_random(320);
      req_tvalid <= 0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (errors == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end
endmodule
